FILE: hw/rtl/nvsp_pkg.sv
// ----------------------------------------------------------------------------
// nvsp_pkg: shared types and constants of the v9 set parser
// Payload structs, template entry layout, result codes.
// ----------------------------------------------------------------------------
package nvsp_pkg;

  localparam int TEMPLATE_ENTRIES = 128;
  localparam int FILL_W = $clog2(TEMPLATE_ENTRIES + 1);

  localparam logic [1:0] KIND_TEMPLATE = 2'd0;
  localparam logic [1:0] KIND_OPTIONS  = 2'd1;
  localparam logic [1:0] KIND_DATA     = 2'd2;
  localparam logic [1:0] KIND_BAD_ID   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PADDING   = 3'd1;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_ID    = 3'd3;
  localparam logic [2:0] ST_SHORT_LEN = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [2:0] REG_PADDING_LIMIT = 3'd0;
  localparam logic [7:0] PADDING_LIMIT_RST = 8'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_t;

  typedef struct packed {
    logic [15:0] set_number;
    logic [1:0]  set_kind;
    logic [15:0] rec_total;
    logic [2:0]  status;
    logic [7:0]  templates_held;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] len;
  } lookup_t;

  function automatic logic [1:0] kind_of(input logic [15:0] id);
    logic [1:0] k;
    if (id == 16'd0) k = KIND_TEMPLATE;
    else if (id == 16'd1) k = KIND_OPTIONS;
    else if (id == 16'd2 || id > 16'd255) k = KIND_DATA;
    else k = KIND_BAD_ID;
    return k;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: hw/rtl/nvsp_cell.sv
// ----------------------------------------------------------------------------
// nvsp_cell: one template table slot
// Holds one entry, shifts it to the next slot on insert, compares the key.
// ----------------------------------------------------------------------------
module nvsp_cell (
  input  logic                 clk,
  input  logic                 shift,
  input  nvsp_pkg::entry_t     din,
  input  logic                 in_use,
  input  logic [15:0]          key,
  output nvsp_pkg::entry_t     dout,
  output logic                 hit,
  output logic [15:0]          hit_len
);

  logic match;

  assign match = in_use && (dout.id == key);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
    hit     <= match;
    hit_len <= match ? dout.len : 16'd0;
  end

endmodule

FILE: hw/rtl/nvsp_table.sv
// ----------------------------------------------------------------------------
// nvsp_table: template table as a shift chain of cells
// New entries enter at the head; lookup result is registered twice.
// ----------------------------------------------------------------------------
module nvsp_table (
  input  logic                            clk,
  input  logic                            wr_en,
  input  nvsp_pkg::entry_t                wr_entry,
  input  logic [nvsp_pkg::FILL_W-1:0]     fill,
  input  logic [15:0]                     key,
  output nvsp_pkg::lookup_t               result
);

  nvsp_pkg::entry_t chain [nvsp_pkg::TEMPLATE_ENTRIES];
  logic [nvsp_pkg::TEMPLATE_ENTRIES-1:0] hits;
  logic [15:0] lens [nvsp_pkg::TEMPLATE_ENTRIES];
  logic [nvsp_pkg::TEMPLATE_ENTRIES-1:0] in_use;
  logic [15:0] len_or;

  for (genvar g = 0; g < nvsp_pkg::TEMPLATE_ENTRIES; g++) begin : g_cell
    assign in_use[g] = (32'(fill) > g);
    if (g == 0) begin : g_head
      nvsp_cell u_cell (
        .clk(clk), .shift(wr_en), .din(wr_entry), .in_use(in_use[g]), .key(key),
        .dout(chain[g]), .hit(hits[g]), .hit_len(lens[g])
      );
    end else begin : g_body
      nvsp_cell u_cell (
        .clk(clk), .shift(wr_en), .din(chain[g-1]), .in_use(in_use[g]), .key(key),
        .dout(chain[g]), .hit(hits[g]), .hit_len(lens[g])
      );
    end
  end

  // ids are unique in the table, so at most one length is nonzero
  always_comb begin
    len_or = 16'd0;
    for (int i = 0; i < nvsp_pkg::TEMPLATE_ENTRIES; i++) begin
      len_or = len_or | lens[i];
    end
  end

  always_ff @(posedge clk) begin
    result.hit <= |hits;
    result.len <= len_or;
  end

endmodule

FILE: hw/rtl/netflow_v9_set_parser_unit.sv
// ----------------------------------------------------------------------------
// netflow_v9_set_parser_unit: byte-serial v9 set parser, top level
// Output: out_item is registered in the cycle after the byte that ends a set.
// Throughput: one byte per cycle while the output is not held; a byte that needs
// a template lookup (the last header byte of a data set, the fourth byte of a
// template record) waits until the result has passed the cell and table registers.
// Reset: synchronous; control state cleared, padding_limit = 4, table empty.
// ----------------------------------------------------------------------------
module netflow_v9_set_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nvsp_pkg::in_t       in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output nvsp_pkg::out_t      out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [6:0] {
    PH_HDR    = 7'b0000001,
    PH_TREC   = 7'b0000010,
    PH_TFIELD = 7'b0000100,
    PH_PAD    = 7'b0001000,
    PH_OREC   = 7'b0010000,
    PH_OBODY  = 7'b0100000,
    PH_DATA   = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  pos, pos_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] current_set, current_set_next;
  logic [7:0]  byte_hold, byte_hold_next;
  logic [15:0] field_left, field_left_next;
  logic [15:0] length_sum, length_sum_next;
  logic [15:0] record_len, record_len_next;
  logic [15:0] record_tally, record_tally_next;
  logic [15:0] record_bytes, record_bytes_next;
  logic [15:0] record_id, record_id_next;
  logic        halted, halted_next;
  logic        skip_record, skip_record_next;
  logic        table_full, table_full_next;
  logic        tmpl_known, tmpl_known_next;
  logic [nvsp_pkg::FILL_W-1:0] fill, fill_next;
  logic [7:0]  padding_limit;

  logic        acc, emit, wr_en, need_lookup, eff_halted;
  logic [1:0]  lk_wait;
  logic [15:0] key;
  phase_t      eff_phase;
  logic [2:0]  eff_pos;
  nvsp_pkg::out_t    res;
  nvsp_pkg::entry_t  wr_entry;
  nvsp_pkg::lookup_t lk;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == nvsp_pkg::REG_PADDING_LIMIT) ? {24'd0, padding_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      padding_limit <= nvsp_pkg::PADDING_LIMIT_RST;
    end else if (psel && penable && pwrite && paddr == nvsp_pkg::REG_PADDING_LIMIT) begin
      padding_limit <= pwdata[7:0];
    end
  end

  // lookup gating; the key follows registered state only
  assign eff_halted = halted && !in_item.message_start;
  assign eff_phase  = in_item.message_start ? PH_HDR : phase;
  assign eff_pos    = in_item.message_start ? 3'd0 : pos;
  assign key        = (phase == PH_HDR) ? current_set : record_id;
  assign need_lookup = !eff_halted && eff_pos == 3'd3 &&
                       ((eff_phase == PH_HDR &&
                         nvsp_pkg::kind_of(current_set) == nvsp_pkg::KIND_DATA) ||
                        eff_phase == PH_TREC);

  assign in_ready = (!out_valid || out_ready) && (!need_lookup || lk_wait == 2'd2);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_wait <= 2'd0;
    end else if (acc) begin
      lk_wait <= 2'd0;
    end else if (lk_wait != 2'd2) begin
      lk_wait <= lk_wait + 2'd1;
    end
  end

  nvsp_table u_table (
    .clk(clk), .wr_en(wr_en), .wr_entry(wr_entry), .fill(fill), .key(key), .result(lk)
  );

  always_comb begin
    logic [15:0] val;
    logic [15:0] blen;
    logic [1:0]  kind;
    logic        store_rec;
    logic        finish;
    phase_next        = phase;
    pos_next          = pos;
    bytes_left_next   = bytes_left;
    current_set_next  = current_set;
    byte_hold_next    = byte_hold;
    field_left_next   = field_left;
    length_sum_next   = length_sum;
    record_len_next   = record_len;
    record_tally_next = record_tally;
    record_bytes_next = record_bytes;
    record_id_next    = record_id;
    halted_next       = halted;
    skip_record_next  = skip_record;
    table_full_next   = table_full;
    tmpl_known_next   = tmpl_known;
    fill_next         = fill;
    emit     = 1'b0;
    res      = '0;
    store_rec = 1'b0;
    finish   = 1'b0;
    val      = {byte_hold, in_item.data_byte};
    kind     = nvsp_pkg::kind_of(current_set);
    blen     = bytes_left;
    if (in_item.message_start) begin
      halted_next = 1'b0;
      phase_next  = PH_HDR;
      pos_next    = 3'd0;
    end
    if (!eff_halted) begin
      if (eff_phase == PH_HDR) begin
        if (eff_pos == 3'd0 || eff_pos == 3'd2) begin
          byte_hold_next = in_item.data_byte;
          pos_next = eff_pos + 3'd1;
        end else if (eff_pos == 3'd1) begin
          current_set_next = val;
          pos_next = 3'd2;
        end else begin
          pos_next = 3'd0;
          if (kind == nvsp_pkg::KIND_BAD_ID) begin
            halted_next = 1'b1;
            emit = 1'b1;
            res.set_kind = nvsp_pkg::KIND_BAD_ID;
            res.status = nvsp_pkg::ST_BAD_ID;
          end else if (val < 16'd4) begin
            halted_next = 1'b1;
            emit = 1'b1;
            res.set_kind = kind;
            res.status = nvsp_pkg::ST_SHORT_LEN;
          end else begin
            blen = val - 16'd4;
            record_tally_next = 16'd0;
            record_bytes_next = 16'd0;
            table_full_next = 1'b0;
            tmpl_known_next = (kind == nvsp_pkg::KIND_DATA) && lk.hit;
            record_len_next = (kind == nvsp_pkg::KIND_DATA && lk.hit) ? lk.len : 16'd0;
            unique case (kind)
              nvsp_pkg::KIND_TEMPLATE: phase_next = PH_TREC;
              nvsp_pkg::KIND_OPTIONS:  phase_next = PH_OREC;
              default:                 phase_next = PH_DATA;
            endcase
            finish = (blen == 16'd0);
          end
        end
      end else begin
        unique case (eff_phase)
          PH_TREC: begin
            if (eff_pos == 3'd0 && bytes_left < 16'd4) begin
              phase_next = PH_PAD;
            end else if (eff_pos == 3'd0 || eff_pos == 3'd2) begin
              byte_hold_next = in_item.data_byte;
              pos_next = eff_pos + 3'd1;
            end else if (eff_pos == 3'd1) begin
              record_id_next = val;
              pos_next = 3'd2;
            end else begin
              field_left_next = val;
              pos_next = 3'd0;
              record_tally_next = nvsp_pkg::sat_add16(record_tally, 16'd1);
              skip_record_next = lk.hit;
              length_sum_next = 16'd0;
              if (val == 16'd0) begin
                store_rec = !lk.hit;
              end else begin
                phase_next = PH_TFIELD;
              end
            end
          end
          PH_TFIELD: begin
            if (eff_pos < 3'd3) begin
              byte_hold_next = in_item.data_byte;
              pos_next = eff_pos + 3'd1;
            end else begin
              pos_next = 3'd0;
              if (!skip_record) begin
                length_sum_next = nvsp_pkg::sat_add16(length_sum, val);
              end
              field_left_next = field_left - 16'd1;
              if (field_left == 16'd1) begin
                store_rec = !skip_record;
                phase_next = PH_TREC;
              end
            end
          end
          PH_OREC: begin
            if (eff_pos == 3'd0 && bytes_left <= 16'd2) begin
              phase_next = PH_PAD;
            end else begin
              if (eff_pos == 3'd0) begin
                record_tally_next = nvsp_pkg::sat_add16(record_tally, 16'd1);
              end
              if (eff_pos == 3'd3) begin
                field_left_next = val;
                pos_next = 3'd4;
              end else if (eff_pos == 3'd5) begin
                field_left_next = nvsp_pkg::sat_add16(field_left, val);
                pos_next = 3'd0;
                if (field_left_next != 16'd0) phase_next = PH_OBODY;
              end else begin
                byte_hold_next = in_item.data_byte;
                pos_next = eff_pos + 3'd1;
              end
            end
          end
          PH_OBODY: begin
            if (field_left != 16'd0) field_left_next = field_left - 16'd1;
            if (field_left_next == 16'd0) phase_next = PH_OREC;
          end
          PH_DATA: begin
            if (tmpl_known && record_len != 16'd0) begin
              record_bytes_next = record_bytes + 16'd1;
              if (record_bytes_next >= record_len) begin
                record_tally_next = nvsp_pkg::sat_add16(record_tally, 16'd1);
                record_bytes_next = 16'd0;
              end
            end
          end
          default: begin
          end
        endcase
        if (bytes_left != 16'd0) blen = bytes_left - 16'd1;
        finish = (blen == 16'd0);
      end
      if (store_rec) begin
        if (32'(fill) < nvsp_pkg::TEMPLATE_ENTRIES) begin
          fill_next = fill + 1'b1;
        end else begin
          table_full_next = 1'b1;
        end
      end
      bytes_left_next = blen;
      if (finish) begin
        phase_next = PH_HDR;
        pos_next = 3'd0;
        emit = 1'b1;
        res.set_kind = kind;
        if (kind == nvsp_pkg::KIND_TEMPLATE) begin
          res.rec_total = record_tally_next;
          res.status = table_full_next ? nvsp_pkg::ST_FULL : nvsp_pkg::ST_OK;
        end else if (kind == nvsp_pkg::KIND_OPTIONS) begin
          res.rec_total = record_tally_next;
          res.status = nvsp_pkg::ST_OK;
        end else if (!tmpl_known_next) begin
          res.rec_total = 16'd1;
          res.status = nvsp_pkg::ST_OK;
        end else if (record_len_next == 16'd0) begin
          res.rec_total = 16'd0;
          res.status = nvsp_pkg::ST_ZERO_LEN;
        end else begin
          res.rec_total = record_tally_next;
          res.status = ({8'd0, padding_limit} < record_bytes_next) ?
                       nvsp_pkg::ST_PADDING : nvsp_pkg::ST_OK;
        end
      end
    end
    res.set_number = current_set_next;
    res.templates_held = 8'(fill_next);
    wr_en = acc && store_rec && (32'(fill) < nvsp_pkg::TEMPLATE_ENTRIES);
    wr_entry.id  = record_id;
    wr_entry.len = length_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      pos          <= 3'd0;
      bytes_left   <= 16'd0;
      current_set  <= 16'd0;
      byte_hold    <= 8'd0;
      field_left   <= 16'd0;
      length_sum   <= 16'd0;
      record_len   <= 16'd0;
      record_tally <= 16'd0;
      record_bytes <= 16'd0;
      record_id    <= 16'd0;
      halted       <= 1'b0;
      skip_record  <= 1'b0;
      table_full   <= 1'b0;
      tmpl_known   <= 1'b0;
      fill         <= '0;
    end else if (acc) begin
      phase        <= phase_next;
      pos          <= pos_next;
      bytes_left   <= bytes_left_next;
      current_set  <= current_set_next;
      byte_hold    <= byte_hold_next;
      field_left   <= field_left_next;
      length_sum   <= length_sum_next;
      record_len   <= record_len_next;
      record_tally <= record_tally_next;
      record_bytes <= record_bytes_next;
      record_id    <= record_id_next;
      halted       <= halted_next;
      skip_record  <= skip_record_next;
      table_full   <= table_full_next;
      tmpl_known   <= tmpl_known_next;
      fill         <= fill_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_item <= res;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= nvsp_pkg::TEMPLATE_ENTRIES) else $error("template count overflow");

  a_lookup_ready: assert property (@(posedge clk) disable iff (rst)
    acc && need_lookup |-> lk_wait == 2'd2) else $error("byte taken before lookup done");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    acc && eff_halted |-> !emit) else $error("result while halted");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> 32'(fill) < nvsp_pkg::TEMPLATE_ENTRIES) else $error("insert into full table");

endmodule
